[rtl/core/mqp_pkg.sv]
package mqp_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int NIB_W = 4;
    localparam int LEN_W = 28;
    localparam int TLEN_W = 16;
    localparam int ROLE_W = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W = 3;
    localparam int SHIFT_W = 5;

    // Most remaining-length bytes a packet may carry
    localparam int MAX_LENGTH_BYTES = 4;

    // Stream widths
    localparam int OUT_FIELDS_W = BYTE_W + 2 * NIB_W + LEN_W + TLEN_W + LEN_W + STAT_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Packet types
    localparam logic [NIB_W-1:0] TYPE_CONNECT    = 4'd1;
    localparam logic [NIB_W-1:0] TYPE_CONNACK    = 4'd2;
    localparam logic [NIB_W-1:0] TYPE_PUBLISH    = 4'd3;
    localparam logic [NIB_W-1:0] TYPE_PUBACK     = 4'd4;
    localparam logic [NIB_W-1:0] TYPE_SUBSCRIBE  = 4'd8;
    localparam logic [NIB_W-1:0] TYPE_SUBACK     = 4'd9;
    localparam logic [NIB_W-1:0] TYPE_PINGREQ    = 4'd12;
    localparam logic [NIB_W-1:0] TYPE_PINGRESP   = 4'd13;
    localparam logic [NIB_W-1:0] TYPE_DISCONNECT = 4'd14;

    localparam logic [NIB_W-1:0] FLAGS_NONE      = 4'h0;
    localparam logic [NIB_W-1:0] FLAGS_SUBSCRIBE = 4'h2;
    localparam logic [1:0]       QOS_ZERO        = 2'h0;
    localparam logic [1:0]       QOS_BAD         = 2'h3;

    // Byte roles
    localparam logic [ROLE_W-1:0] ROLE_HEADER  = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_TLEN    = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_OTHER   = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_DISCARD = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_PROTOCOL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MALFORMED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 2'd3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_PAYLOAD,
        PH_OTHER,
        PH_DISCARD
    } phase_t;

    // One classified byte, as queued between front and back end
    typedef struct packed {
        logic              hdr_ok;
        logic              start;
        logic [BYTE_W-1:0] data;
    } entry_t;

    // Header check: type and flag nibble taken from one byte
    function automatic logic header_ok(input logic [BYTE_W-1:0] b);
        logic [NIB_W-1:0] ptype;
        logic [NIB_W-1:0] flags;
        logic             ok;
        ptype = b[7:4];
        flags = b[3:0];
        case (ptype)
            TYPE_CONNECT, TYPE_CONNACK, TYPE_PUBACK, TYPE_SUBACK,
            TYPE_PINGREQ, TYPE_PINGRESP, TYPE_DISCONNECT:
                ok = (flags == FLAGS_NONE);
            TYPE_PUBLISH:
                ok = (flags[2:1] != QOS_BAD);
            TYPE_SUBSCRIBE:
                ok = (flags == FLAGS_SUBSCRIBE);
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

[rtl/core/mqp_front.sv]
module mqp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mqp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic [0:0]                    s_tuser,   // [0] frame_start
    output mqp_pkg::entry_t               q_entry,
    output logic                          q_valid,
    input  logic                          q_pop
);

    mqp_pkg::entry_t                  queue_reg [mqp_pkg::QUEUE_DEPTH];
    logic [mqp_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mqp_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mqp_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             push;
    logic                             pop;
    mqp_pkg::entry_t                  new_entry;

    // Classify the incoming byte
    always_comb
    begin
        new_entry.data   = s_tdata;
        new_entry.start  = s_tuser[0];
        new_entry.hdr_ok = mqp_pkg::header_ok(s_tdata);
    end

    assign s_tready = (count_reg != mqp_pkg::QCNT_W'(mqp_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = queue_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mqp_pkg::QPTR_W'(mqp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + mqp_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mqp_pkg::QPTR_W'(mqp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + mqp_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + mqp_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - mqp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

[rtl/core/mqp_back.sv]
module mqp_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mqp_pkg::entry_t                   q_entry,
    input  logic                              q_valid,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] byte_echo, [11:8] packet_type, [15:12] packet_flags,
    // [43:16] body_length, [59:44] topic_size, [87:60] payload_length,
    // [89:88] status, rest zero
    output logic [mqp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [mqp_pkg::ROLE_W-1:0]        m_tuser,   // [2:0] byte_role
    output logic                              m_tlast
);

    // Parser state
    mqp_pkg::phase_t                  phase_reg, phase_next;
    logic [mqp_pkg::NIB_W-1:0]        type_reg, type_next;
    logic [mqp_pkg::NIB_W-1:0]        flags_reg, flags_next;
    logic [mqp_pkg::LEN_W-1:0]        acc_reg, acc_next;
    logic [mqp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [mqp_pkg::LEN_W-1:0]        left_reg, left_next;
    logic [mqp_pkg::TLEN_W-1:0]       tlen_reg, tlen_next;
    logic [mqp_pkg::TLEN_W-1:0]       tleft_reg, tleft_next;
    logic [mqp_pkg::LEN_W-1:0]        pay_reg, pay_next;

    // Output register
    logic                             out_valid_reg;
    logic [mqp_pkg::BYTE_W-1:0]       out_byte_reg;
    logic [mqp_pkg::ROLE_W-1:0]       out_role_reg;
    logic [mqp_pkg::NIB_W-1:0]        out_type_reg;
    logic [mqp_pkg::NIB_W-1:0]        out_flags_reg;
    logic [mqp_pkg::LEN_W-1:0]        out_body_reg;
    logic [mqp_pkg::TLEN_W-1:0]       out_tlen_reg;
    logic [mqp_pkg::LEN_W-1:0]        out_pay_reg;
    logic [mqp_pkg::STAT_W-1:0]       out_stat_reg;
    logic                             out_last_reg;

    // Per-byte results
    logic [mqp_pkg::ROLE_W-1:0]       role;
    logic [mqp_pkg::STAT_W-1:0]       status;
    logic                             last;
    logic                             show_pay;
    logic [mqp_pkg::BYTE_W-1:0]       b;
    logic [mqp_pkg::SHIFT_W-1:0]      shift_amt;
    logic [mqp_pkg::LEN_W-1:0]        left_dec;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign b        = q_entry.data;
    assign left_dec = left_reg - mqp_pkg::LEN_W'(1);
    // 7 * group index, as 8c - c
    assign shift_amt = {cnt_reg[1:0], 3'b000} - {3'b000, cnt_reg[1:0]};

    // Parser next state and per-byte labels
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        pay_next   = pay_reg;
        role       = mqp_pkg::ROLE_DISCARD;
        status     = mqp_pkg::ST_OK;
        last       = 1'b0;
        show_pay   = 1'b0;

        if (q_entry.start || phase_reg == mqp_pkg::PH_HEADER)
        begin
            // Header byte: start a fresh packet
            role       = mqp_pkg::ROLE_HEADER;
            type_next  = b[7:4];
            flags_next = b[3:0];
            acc_next   = '0;
            cnt_next   = '0;
            left_next  = '0;
            tlen_next  = '0;
            tleft_next = '0;
            if (q_entry.hdr_ok)
            begin
                phase_next = mqp_pkg::PH_LENGTH;
            end
            else
            begin
                status     = mqp_pkg::ST_PROTOCOL;
                last       = 1'b1;
                phase_next = mqp_pkg::PH_DISCARD;
            end
        end
        else
        begin
            case (phase_reg)
                mqp_pkg::PH_LENGTH:
                begin
                    role     = mqp_pkg::ROLE_LENGTH;
                    cnt_next = cnt_reg + mqp_pkg::CNT_W'(1);
                    if (cnt_next > mqp_pkg::CNT_W'(mqp_pkg::MAX_LENGTH_BYTES))
                    begin
                        status     = mqp_pkg::ST_PROTOCOL;
                        last       = 1'b1;
                        phase_next = mqp_pkg::PH_DISCARD;
                    end
                    else
                    begin
                        acc_next = acc_reg + (mqp_pkg::LEN_W'(b[6:0]) << shift_amt);
                        if (!b[7])
                        begin
                            // Last length byte
                            left_next = acc_next;
                            if (type_reg == mqp_pkg::TYPE_PUBLISH)
                            begin
                                if (flags_reg[2:1] != mqp_pkg::QOS_ZERO)
                                begin
                                    status     = mqp_pkg::ST_UNSUPPORTED;
                                    last       = 1'b1;
                                    phase_next = mqp_pkg::PH_DISCARD;
                                end
                                else if (acc_next < mqp_pkg::LEN_W'(2))
                                begin
                                    status     = mqp_pkg::ST_MALFORMED;
                                    last       = 1'b1;
                                    phase_next = mqp_pkg::PH_DISCARD;
                                end
                                else
                                begin
                                    phase_next = mqp_pkg::PH_TLEN_HI;
                                end
                            end
                            else if (acc_next == '0)
                            begin
                                last       = 1'b1;
                                phase_next = mqp_pkg::PH_HEADER;
                            end
                            else
                            begin
                                phase_next = mqp_pkg::PH_OTHER;
                            end
                        end
                    end
                end
                mqp_pkg::PH_TLEN_HI:
                begin
                    role       = mqp_pkg::ROLE_TLEN;
                    tlen_next  = {b, 8'h00};
                    left_next  = left_dec;
                    // body minus the two topic-length bytes, topic taken off next byte
                    pay_next   = acc_reg - mqp_pkg::LEN_W'(2);
                    phase_next = mqp_pkg::PH_TLEN_LO;
                end
                mqp_pkg::PH_TLEN_LO:
                begin
                    role      = mqp_pkg::ROLE_TLEN;
                    tlen_next = {tlen_reg[15:8], b};
                    left_next = left_dec;
                    if (mqp_pkg::LEN_W'(tlen_next) > left_next)
                    begin
                        status     = mqp_pkg::ST_MALFORMED;
                        last       = 1'b1;
                        phase_next = mqp_pkg::PH_DISCARD;
                    end
                    else
                    begin
                        show_pay   = 1'b1;
                        tleft_next = tlen_next;
                        pay_next   = pay_reg - mqp_pkg::LEN_W'(tlen_next);
                        if (left_next == '0)
                        begin
                            last       = 1'b1;
                            phase_next = mqp_pkg::PH_HEADER;
                        end
                        else if (tlen_next != '0)
                        begin
                            phase_next = mqp_pkg::PH_TOPIC;
                        end
                        else
                        begin
                            phase_next = mqp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mqp_pkg::PH_TOPIC:
                begin
                    role       = mqp_pkg::ROLE_TOPIC;
                    show_pay   = 1'b1;
                    left_next  = left_dec;
                    tleft_next = tleft_reg - mqp_pkg::TLEN_W'(1);
                    if (left_next == '0)
                    begin
                        last       = 1'b1;
                        phase_next = mqp_pkg::PH_HEADER;
                    end
                    else if (tleft_next == '0)
                    begin
                        phase_next = mqp_pkg::PH_PAYLOAD;
                    end
                end
                mqp_pkg::PH_PAYLOAD:
                begin
                    role      = mqp_pkg::ROLE_PAYLOAD;
                    show_pay  = 1'b1;
                    left_next = left_dec;
                    if (left_next == '0)
                    begin
                        last       = 1'b1;
                        phase_next = mqp_pkg::PH_HEADER;
                    end
                end
                mqp_pkg::PH_OTHER:
                begin
                    role      = mqp_pkg::ROLE_OTHER;
                    left_next = left_dec;
                    if (left_next == '0)
                    begin
                        last       = 1'b1;
                        phase_next = mqp_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    role       = mqp_pkg::ROLE_DISCARD;
                    phase_next = mqp_pkg::PH_DISCARD;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mqp_pkg::PH_HEADER;
            type_reg      <= '0;
            flags_reg     <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            tlen_reg      <= '0;
            tleft_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                flags_reg <= flags_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                left_reg  <= left_next;
                tlen_reg  <= tlen_next;
                tleft_reg <= tleft_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pay_reg       <= pay_next;
            out_byte_reg  <= b;
            out_role_reg  <= role;
            out_type_reg  <= type_next;
            out_flags_reg <= flags_next;
            out_body_reg  <= acc_next;
            out_tlen_reg  <= tlen_next;
            out_pay_reg   <= show_pay ? pay_next : '0;
            out_stat_reg  <= status;
            out_last_reg  <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_role_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{mqp_pkg::OUT_PAD_W{1'b0}}, out_stat_reg, out_pay_reg, out_tlen_reg,
                       out_body_reg, out_flags_reg, out_type_reg, out_byte_reg};

    // Discarded bytes never end a packet or carry an error
    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == mqp_pkg::ROLE_DISCARD) |->
        (!m_tlast && out_stat_reg == mqp_pkg::ST_OK))
        else $error("discarded byte marked last or with error");

    // Every error closes the packet
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_stat_reg != mqp_pkg::ST_OK) |-> m_tlast)
        else $error("error status without last");

    // Once discarding, only a frame start leaves that state
    a_discard_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_entry.start && phase_reg == mqp_pkg::PH_DISCARD)
        |=> (out_role_reg == mqp_pkg::ROLE_DISCARD))
        else $error("left discard without frame start");

    // Payload length only shows on publish body bytes
    a_payload_roles: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_pay_reg != '0) |->
        (m_tuser == mqp_pkg::ROLE_TLEN || m_tuser == mqp_pkg::ROLE_TOPIC ||
         m_tuser == mqp_pkg::ROLE_PAYLOAD))
        else $error("payload length on a non-publish byte");

endmodule

[rtl/core/mqtt_packet_header_parser.sv]
// MQTT 3.1.1 byte-stream labeller. Each input byte (tdata, with frame_start on
// tuser) yields exactly one output item that echoes the byte, gives its role in
// the packet (on tuser) and the header fields decoded so far; tlast marks the
// final byte of a packet or the byte that raised an error, after which bytes are
// labelled discarded until the next frame_start. Throughput is one byte per clock
// while the output is not stalled: the front end classifies the header bits and
// feeds a two-entry queue, and the back end parses one queued byte per cycle into
// an output register. An accepted byte passes through the queue and then the
// output register before it is offered on the output. Output backpressure holds
// the back end, and the input stalls only once the queue is full. There is no
// configuration and no clearing pass after reset.
module mqtt_packet_header_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mqp_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
    input  logic [0:0]                        s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] byte_echo, [11:8] packet_type, [15:12] packet_flags,
    // [43:16] body_length, [59:44] topic_size, [87:60] payload_length,
    // [89:88] status, rest zero
    output logic [mqp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [mqp_pkg::ROLE_W-1:0]        m_tuser,   // [2:0] byte_role
    output logic                              m_tlast
);

    mqp_pkg::entry_t q_entry;
    logic            q_valid;
    logic            q_pop;

    // Classification and queue
    mqp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_entry  (q_entry),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    // Parser and output register
    mqp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_entry  (q_entry),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/mqtt_packet_header_parser_checker.sv]
module mqtt_packet_header_parser_checker
    import mqp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] frame_start
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] byte_echo, [11:8] packet_type, [15:12] packet_flags,
    // [43:16] body_length, [59:44] topic_size, [87:60] payload_length,
    // [89:88] status, rest zero
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [ROLE_W-1:0]     m_tuser,   // [2:0] byte_role
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending
);

    timeunit 1ns;
    timeprecision 1ps;

    // One labelled byte as the parser should report it
    typedef struct {
        logic [BYTE_W-1:0] echo;
        logic [ROLE_W-1:0] role;
        logic [NIB_W-1:0]  ptype;
        logic [NIB_W-1:0]  flags;
        logic [LEN_W-1:0]  body_len;
        logic [TLEN_W-1:0] topic_size;
        logic [LEN_W-1:0]  pay_size;
        logic [STAT_W-1:0] status;
        logic              last;
    } byte_label_t;

    byte_label_t expected_labels[$];

    // Parser state as predicted
    phase_t            stage = PH_HEADER;
    logic [NIB_W-1:0]  cur_type = '0;
    logic [NIB_W-1:0]  cur_flags = '0;
    logic [LEN_W-1:0]  len_acc = '0;
    logic [CNT_W-1:0]  len_count = '0;
    logic [LEN_W-1:0]  body_left = '0;
    logic [TLEN_W-1:0] tlen_hold = '0;
    logic [TLEN_W-1:0] topic_left = '0;

    initial
    begin
        errors = 0;
        pending = 0;
    end

    // Which type/flag combinations MQTT 3.1.1 allows on a fixed header
    function automatic logic header_allowed(input logic [NIB_W-1:0] t,
                                            input logic [NIB_W-1:0] f);
        if (t == TYPE_PUBLISH)
            return f[2:1] != QOS_BAD;
        if (t == TYPE_SUBSCRIBE)
            return f == FLAGS_SUBSCRIBE;
        if (t == TYPE_CONNECT || t == TYPE_CONNACK || t == TYPE_PUBACK ||
            t == TYPE_SUBACK || t == TYPE_PINGREQ || t == TYPE_PINGRESP ||
            t == TYPE_DISCONNECT)
            return f == FLAGS_NONE;
        return 1'b0;
    endfunction

    // Advance the predicted parser by one byte and produce its label
    task automatic label_byte(input logic [BYTE_W-1:0] b, input logic fs,
                              output byte_label_t r);
        logic show;
        show = 1'b0;
        r.echo = b;
        r.role = ROLE_DISCARD;
        r.status = ST_OK;
        r.last = 1'b0;
        if (fs || stage == PH_HEADER)
        begin
            r.role = ROLE_HEADER;
            cur_type = b[7:4];
            cur_flags = b[3:0];
            len_acc = '0;
            len_count = '0;
            body_left = '0;
            tlen_hold = '0;
            topic_left = '0;
            if (header_allowed(cur_type, cur_flags))
                stage = PH_LENGTH;
            else
            begin
                r.status = ST_PROTOCOL;
                r.last = 1'b1;
                stage = PH_DISCARD;
            end
        end
        else
        begin
            case (stage)
                PH_LENGTH:
                begin
                    r.role = ROLE_LENGTH;
                    len_count = len_count + 3'd1;
                    if (len_count > MAX_LENGTH_BYTES)
                    begin
                        r.status = ST_PROTOCOL;
                        r.last = 1'b1;
                        stage = PH_DISCARD;
                    end
                    else
                    begin
                        // 7-bit groups, least significant first
                        len_acc = len_acc + (LEN_W'(b[6:0]) << (7 * (len_count - 3'd1)));
                        if (!b[7])
                        begin
                            body_left = len_acc;
                            if (cur_type == TYPE_PUBLISH)
                            begin
                                if (cur_flags[2:1] != QOS_ZERO)
                                begin
                                    r.status = ST_UNSUPPORTED;
                                    r.last = 1'b1;
                                    stage = PH_DISCARD;
                                end
                                else if (len_acc < LEN_W'(2))
                                begin
                                    r.status = ST_MALFORMED;
                                    r.last = 1'b1;
                                    stage = PH_DISCARD;
                                end
                                else
                                    stage = PH_TLEN_HI;
                            end
                            else if (len_acc == '0)
                            begin
                                r.last = 1'b1;
                                stage = PH_HEADER;
                            end
                            else
                                stage = PH_OTHER;
                        end
                    end
                end
                PH_TLEN_HI:
                begin
                    r.role = ROLE_TLEN;
                    tlen_hold = {b, 8'h00};
                    body_left = body_left - 1'b1;
                    stage = PH_TLEN_LO;
                end
                PH_TLEN_LO:
                begin
                    r.role = ROLE_TLEN;
                    tlen_hold[7:0] = b;
                    body_left = body_left - 1'b1;
                    if (LEN_W'(tlen_hold) > body_left)
                    begin
                        // topic would run past the end of the body
                        r.status = ST_MALFORMED;
                        r.last = 1'b1;
                        stage = PH_DISCARD;
                    end
                    else
                    begin
                        show = 1'b1;
                        topic_left = tlen_hold;
                        if (body_left == '0)
                        begin
                            r.last = 1'b1;
                            stage = PH_HEADER;
                        end
                        else
                            stage = (topic_left != '0) ? PH_TOPIC : PH_PAYLOAD;
                    end
                end
                PH_TOPIC:
                begin
                    r.role = ROLE_TOPIC;
                    show = 1'b1;
                    body_left = body_left - 1'b1;
                    topic_left = topic_left - 1'b1;
                    if (body_left == '0)
                    begin
                        r.last = 1'b1;
                        stage = PH_HEADER;
                    end
                    else if (topic_left == '0)
                        stage = PH_PAYLOAD;
                end
                PH_PAYLOAD, PH_OTHER:
                begin
                    r.role = (stage == PH_PAYLOAD) ? ROLE_PAYLOAD : ROLE_OTHER;
                    show = (stage == PH_PAYLOAD);
                    body_left = body_left - 1'b1;
                    if (body_left == '0)
                    begin
                        r.last = 1'b1;
                        stage = PH_HEADER;
                    end
                end
                default:
                    stage = PH_DISCARD;
            endcase
        end
        r.ptype = cur_type;
        r.flags = cur_flags;
        r.body_len = len_acc;
        r.topic_size = tlen_hold;
        r.pay_size = show ? (len_acc - LEN_W'(2) - LEN_W'(tlen_hold)) : '0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Predict on input accept, compare on output accept
    always @(posedge clk or negedge rst_n)
    begin : watch
        byte_label_t lbl;
        byte_label_t want;
        if (!rst_n)
        begin
            expected_labels.delete();
            stage = PH_HEADER;
            cur_type = '0;
            cur_flags = '0;
            len_acc = '0;
            len_count = '0;
            body_left = '0;
            tlen_hold = '0;
            topic_left = '0;
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                label_byte(s_tdata, s_tuser[0], lbl);
                expected_labels.push_back(lbl);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_labels.size() == 0)
                begin
                    $error("output item with no expected label: tdata 0x%0h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_labels.pop_front();
                    check_field("byte_echo", want.echo, m_tdata[7:0]);
                    check_field("packet_type", want.ptype, m_tdata[11:8]);
                    check_field("packet_flags", want.flags, m_tdata[15:12]);
                    check_field("body_length", want.body_len, m_tdata[43:16]);
                    check_field("topic_size", want.topic_size, m_tdata[59:44]);
                    check_field("payload_length", want.pay_size, m_tdata[87:60]);
                    check_field("status", want.status, m_tdata[89:88]);
                    check_field("tdata_pad", '0, m_tdata[OUT_DATA_W-1:90]);
                    check_field("byte_role", want.role, m_tuser);
                    check_field("last", want.last, m_tlast);
                end
            end
            pending = expected_labels.size();
        end
    end

endmodule

[tb/mqtt_packet_header_parser_tb.sv]
module mqtt_packet_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mqp_pkg::*;

    localparam int ITEMS_PER_PHASE = 425;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ROLE_W-1:0]     m_tuser;
    logic                  m_tlast;

    int errors;
    int pending;

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   phase_sent = 0;
    logic resync_needed = 1'b0;
    logic [BYTE_W-1:0] pkt_bytes[$];

    // Directed bytes, bit 8 = frame_start
    logic [8:0] directed_seq [33] = '{
        // publish without frame_start, empty topic ends the body
        9'h030, 9'h002, 9'h000, 9'h000,
        // back-to-back disconnect, zero-length body
        9'h0E0, 9'h000,
        // publish QoS 2 with dup and retain: unsupported
        9'h13D, 9'h000,
        // discarded byte, then an illegal header
        9'h0F5, 9'h1FF,
        // publish body too short for a topic length
        9'h131, 9'h001,
        // topic length past end of body
        9'h130, 9'h003, 9'h000, 9'h002,
        // subscribe with the largest length, cut by the next header
        9'h182, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
        // connect with a fifth length byte
        9'h110, 9'h080, 9'h080, 9'h080, 9'h080, 9'h001,
        // publish with topic and payload
        9'h130, 9'h004, 9'h000, 9'h001, 9'h041, 9'h05A
    };

    mqtt_packet_header_parser DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mqtt_packet_header_parser_checker checker_i
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Receiver backpressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Called at a falling edge; returns at the falling edge after the accept
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        phase_sent++;
        @(negedge clk);
    endtask

    task automatic push_length(input int unsigned len);
        logic [BYTE_W-1:0] b;
        do
        begin
            b = {1'b0, 7'(len)};
            len = len >> 7;
            if (len != 0)
                b[7] = 1'b1;
            pkt_bytes.push_back(b);
        end
        while (len != 0);
    endtask

    task automatic push_noise(input int unsigned max_n);
        int unsigned n;
        n = $urandom_range(max_n);
        repeat (n)
            pkt_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [BYTE_W-1:0] pick_good_header();
        logic [NIB_W-1:0] f;
        f = 4'($urandom);
        if (f[2:1] == QOS_BAD)
            f[2] = 1'b0;
        case ($urandom_range(8))
            0: return {TYPE_CONNECT, FLAGS_NONE};
            1: return {TYPE_CONNACK, FLAGS_NONE};
            2: return {TYPE_PUBACK, FLAGS_NONE};
            3: return {TYPE_SUBACK, FLAGS_NONE};
            4: return {TYPE_PINGREQ, FLAGS_NONE};
            5: return {TYPE_PINGRESP, FLAGS_NONE};
            6: return {TYPE_DISCONNECT, FLAGS_NONE};
            7: return {TYPE_SUBSCRIBE, FLAGS_SUBSCRIBE};
            default: return {TYPE_PUBLISH, f};
        endcase
    endfunction

    // One random packet: mostly well formed, the rest broken or noise
    task automatic send_random_packet();
        int unsigned kind;
        int unsigned tl;
        int unsigned pl;
        int unsigned len;
        int unsigned n;
        logic [BYTE_W-1:0] hdr;
        logic fs;
        logic clean;
        fs = resync_needed ? 1'b1 : ($urandom_range(3) == 0);
        kind = $urandom_range(99);
        clean = 1'b0;
        pkt_bytes.delete();
        if (kind < 40)
        begin
            // QoS 0 publish with random topic and payload
            tl = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(7, 40);
            n = $urandom_range(99);
            pl = (n < 90) ? $urandom_range(10) :
                 (n < 98) ? $urandom_range(11, 150) : $urandom_range(200, 400);
            pkt_bytes.push_back({TYPE_PUBLISH, 4'($urandom) & 4'b1001});
            push_length(2 + tl + pl);
            pkt_bytes.push_back(8'(tl >> 8));
            pkt_bytes.push_back(8'(tl));
            repeat (tl + pl)
                pkt_bytes.push_back(8'($urandom));
            clean = 1'b1;
        end
        else if (kind < 60)
        begin
            // other legal packet with an opaque body
            hdr = pick_good_header();
            if (hdr[7:4] == TYPE_PUBLISH)
                hdr = {TYPE_SUBSCRIBE, FLAGS_SUBSCRIBE};
            len = $urandom_range(12);
            pkt_bytes.push_back(hdr);
            push_length(len);
            repeat (len)
                pkt_bytes.push_back(8'($urandom));
            clean = 1'b1;
        end
        else if (kind < 65)
        begin
            // publish QoS 1 or 2
            pkt_bytes.push_back({TYPE_PUBLISH, 1'($urandom), 2'($urandom_range(1, 2)),
                                 1'($urandom)});
            push_length($urandom_range(300));
            push_noise(3);
        end
        else if (kind < 69)
        begin
            // publish body too short
            pkt_bytes.push_back({TYPE_PUBLISH, 4'($urandom) & 4'b1001});
            push_length($urandom_range(1));
            push_noise(3);
        end
        else if (kind < 74)
        begin
            // topic length overruns the body
            len = $urandom_range(2, 12);
            tl = $urandom_range(1) ? $urandom_range(len - 1, len + 4) :
                                     $urandom_range(len - 1, 65535);
            pkt_bytes.push_back({TYPE_PUBLISH, 4'($urandom) & 4'b1001});
            push_length(len);
            pkt_bytes.push_back(8'(tl >> 8));
            pkt_bytes.push_back(8'(tl));
            push_noise(3);
        end
        else if (kind < 79)
        begin
            // illegal type or flags
            do
                hdr = 8'($urandom);
            while (header_ok(hdr));
            pkt_bytes.push_back(hdr);
            push_noise(3);
        end
        else if (kind < 84)
        begin
            // five length bytes
            pkt_bytes.push_back(pick_good_header());
            repeat (MAX_LENGTH_BYTES)
                pkt_bytes.push_back(8'($urandom) | 8'h80);
            pkt_bytes.push_back(8'($urandom));
            push_noise(3);
        end
        else if (kind < 90)
        begin
            // large length, cut short by the next header
            pkt_bytes.push_back(pick_good_header());
            push_length($urandom_range(128, 28'hFFFFFFF));
            push_noise(4);
        end
        if (kind < 90)
        begin
            n = pkt_bytes.size();
            // sometimes a complete packet is cut by the next header
            if (clean && n > 1 && $urandom_range(9) == 0)
            begin
                n = $urandom_range(1, n - 1);
                clean = 1'b0;
            end
            for (int unsigned i = 0; i < n; i++)
                send_byte(pkt_bytes[i], (i == 0) ? fs : 1'b0);
        end
        else
        begin
            // noise with random frame_start
            n = $urandom_range(1, 6);
            repeat (n)
                send_byte(8'($urandom), $urandom_range(9) < 3);
        end
        resync_needed = !clean;
    endtask

    // Hold the sender until every expected label has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        phase_sent = 0;
        while (phase_sent < ITEMS_PER_PHASE)
            send_random_packet();
        drain();
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_seq[i])
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        drain();

        run_phase(0, 0);
        run_phase(49, 0);
        run_phase(0, 49);
        run_phase(32, 32);

        sink_stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
